// ===== rtl/core/coefficient_distance_accumulator_core_macros.svh =====
// Assertion macros used by cda_back.
`ifndef COEFFICIENT_DISTANCE_ACCUMULATOR_CORE_MACROS_SVH
`define COEFFICIENT_DISTANCE_ACCUMULATOR_CORE_MACROS_SVH

// Property checked on every clock while out of reset.
`define CDA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define CDA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cda_pkg.sv =====
`timescale 1ns / 1ps
package cda_pkg;

  localparam int unsigned COEF_W      = 32;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned ROWC_W      = 9;
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ROWC_W-1:0] MAX_ROWS  = 9'd256;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [22:0]       ONE_Q16   = 23'd65536;

  // metric_mode codes
  localparam logic [2:0] MODE_FRACTION = 3'd0;
  localparam logic [2:0] MODE_LOG      = 3'd1;
  localparam logic [2:0] MODE_WLOG     = 3'd2;
  localparam logic [2:0] MODE_PRES_ABS = 3'd3;
  localparam logic [2:0] MODE_ABS_PRES = 3'd4;

  // register indexes
  localparam logic [1:0] REG_METRIC_MODE = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd1;

  typedef struct packed {
    logic [2:0]          mode;
    logic [COEF_W-1:0]   diff;
    logic [COEF_W:0]     den;
    logic [WEIGHT_W-1:0] weight;
    logic                a_nz;
    logic                b_nz;
    logic                last;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQR,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_ACC
  } back_state_e;

endpackage

// ===== rtl/core/cda_front.sv =====
`timescale 1ns / 1ps
module cda_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [8:0]           cfg_data_i,
  input  logic [31:0]          coef_a_i,
  input  logic [31:0]          coef_b_i,
  input  logic [7:0]           row_index_i,
  input  logic                 last_pair_i,
  output cda_pkg::pair_t       pair_o
);

  logic [2:0]                   mode_q;
  logic [cda_pkg::ROWC_W-1:0]   rowc_q;
  logic [cda_pkg::ROWC_W-1:0]   base;
  logic [2*cda_pkg::ROWC_W-1:0] sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cda_pkg::MODE_FRACTION;
      rowc_q <= 9'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cda_pkg::REG_METRIC_MODE) mode_q <= cfg_data_i[2:0];
      else if (cfg_idx_i == cda_pkg::REG_ROW_COUNT) rowc_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (row_index_i != '0) begin
      base = {1'b0, row_index_i};
    end else if (rowc_q == '0) begin
      base = 9'd1;
    end else if (rowc_q > cda_pkg::MAX_ROWS) begin
      base = cda_pkg::MAX_ROWS;
    end else begin
      base = rowc_q;
    end
    sq = base * base;
    pair_o.mode   = mode_q;
    pair_o.diff   = (coef_a_i >= coef_b_i) ? coef_a_i - coef_b_i : coef_b_i - coef_a_i;
    pair_o.den    = {1'b0, coef_a_i} + {1'b0, coef_b_i};
    // plain log mode divides by one
    pair_o.weight = (mode_q == cda_pkg::MODE_WLOG) ? sq[cda_pkg::WEIGHT_W-1:0]
                                                   : cda_pkg::WEIGHT_W'(1);
    pair_o.a_nz   = (coef_a_i != '0);
    pair_o.b_nz   = (coef_b_i != '0);
    pair_o.last   = last_pair_i;
  end

endmodule

// ===== rtl/core/cda_queue.sv =====
`timescale 1ns / 1ps
module cda_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cda_pkg::pair_t         wr_pair_i,
  input  logic                   pop_i,
  output cda_pkg::pair_t         rd_pair_o,
  output cda_pkg::queue_status_t status_o
);

  cda_pkg::pair_t                mem_q [cda_pkg::QUEUE_DEPTH];
  logic [cda_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [cda_pkg::QCNT_W-1:0]    cnt_q;
  logic                          do_push, do_pop;

  assign status_o.full  = (cnt_q == cda_pkg::QCNT_W'(cda_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rd_pair_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wr_pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == cda_pkg::QPTR_W'(cda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == cda_pkg::QPTR_W'(cda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/cda_back.sv =====
`timescale 1ns / 1ps
`include "coefficient_distance_accumulator_core_macros.svh"
module cda_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cda_pkg::pair_t         pair_i,
  input  cda_pkg::queue_status_t qstat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [47:0]            distance_o,
  output logic                   saturated_o
);

  cda_pkg::back_state_e state_q, state_d;
  cda_pkg::pair_t       ent_q, ent_d;
  logic [32:0] norm_q, norm_d, norm_n;
  logic [5:0]  lz_q, lz_d, lz_n, sh;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] mant_q, mant_d;
  logic [19:0] frac_q, frac_d;
  logic [57:0] prod_q, prod_d;
  logic [32:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [22:0] num_q, num_d, quo_q, quo_d, quo_n;
  logic [22:0] term_q, term_d;
  logic [47:0] sum_q, sum_d, out_dist_q, out_dist_d;
  logic        ovf_q, ovf_d, out_val_q, out_val_d, out_sat_q, out_sat_d;
  logic [48:0] fnum;
  logic [61:0] sq;
  logic [31:0] m2;
  logic [25:0] lval;
  logic [58:0] lnum;
  logic [33:0] trial;
  logic [47:0] term_w;
  logic        go;

  assign go = !ent_q.last || !out_val_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cda_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          if (pair_i.mode == cda_pkg::MODE_FRACTION) begin
            state_d = (pair_i.den == '0) ? cda_pkg::ST_ACC : cda_pkg::ST_DIV;
          end else if (pair_i.mode == cda_pkg::MODE_LOG || pair_i.mode == cda_pkg::MODE_WLOG) begin
            state_d = cda_pkg::ST_NORM;
          end else begin
            state_d = cda_pkg::ST_ACC;
          end
        end
      end
      cda_pkg::ST_NORM:  if (cnt_q == 5'd5) state_d = cda_pkg::ST_SQR;
      cda_pkg::ST_SQR:   if (cnt_q == 5'd19) state_d = cda_pkg::ST_MUL;
      cda_pkg::ST_MUL:   state_d = cda_pkg::ST_DLOAD;
      cda_pkg::ST_DLOAD: state_d = cda_pkg::ST_DIV;
      cda_pkg::ST_DIV:   if (cnt_q == 5'd1) state_d = cda_pkg::ST_ACC;
      cda_pkg::ST_ACC:   if (go) state_d = cda_pkg::ST_IDLE;
      default:           state_d = cda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ent_d = ent_q; norm_d = norm_q; lz_d = lz_q; cnt_d = cnt_q; mant_d = mant_q;
    frac_d = frac_q; prod_d = prod_q; rem_d = rem_q; dsr_d = dsr_q; num_d = num_q;
    quo_d = quo_q; term_d = term_q; sum_d = sum_q; ovf_d = ovf_q;
    out_dist_d = out_dist_q; out_sat_d = out_sat_q;
    out_val_d = out_val_q && !out_ready_i;
    pop_o = 1'b0;

    fnum  = {1'b0, pair_i.diff, 16'b0} + {17'b0, pair_i.den[32:1]};
    sh    = 6'd32 >> cnt_q[2:0];
    if ((norm_q >> (6'd33 - sh)) == '0) begin
      norm_n = norm_q << sh;
      lz_n   = lz_q + sh;
    end else begin
      norm_n = norm_q;
      lz_n   = lz_q;
    end
    sq    = mant_q * mant_q;
    m2    = sq[61:30];
    lval  = {(6'd32 - lz_q), frac_q};
    lnum  = {1'b0, prod_q} + ({42'b0, ent_q.weight} << 35);
    trial = {rem_q, num_q[22]};
    if (trial >= {1'b0, dsr_q}) begin
      quo_n = {quo_q[21:0], 1'b1};
    end else begin
      quo_n = {quo_q[21:0], 1'b0};
    end
    term_w = {25'b0, term_q};

    unique case (state_q)
      cda_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o  = 1'b1;
          ent_d  = pair_i;
          term_d = '0;
          quo_d  = '0;
          cnt_d  = '0;
          lz_d   = '0;
          frac_d = '0;
          norm_d = {1'b0, pair_i.diff} + 33'd1;
          rem_d  = {1'b0, fnum[48:17]};
          num_d  = {fnum[16:0], 6'b0};
          dsr_d  = pair_i.den;
          if (pair_i.mode == cda_pkg::MODE_FRACTION) begin
            cnt_d = 5'd17;
          end else if (pair_i.mode == cda_pkg::MODE_PRES_ABS) begin
            term_d = (pair_i.a_nz && !pair_i.b_nz) ? cda_pkg::ONE_Q16 : '0;
          end else if (pair_i.mode == cda_pkg::MODE_ABS_PRES) begin
            term_d = (!pair_i.a_nz && pair_i.b_nz) ? cda_pkg::ONE_Q16 : '0;
          end
        end
      end
      cda_pkg::ST_NORM: begin
        norm_d = norm_n;
        lz_d   = lz_n;
        cnt_d  = (cnt_q == 5'd5) ? '0 : cnt_q + 5'd1;
        mant_d = norm_n[32:2];
      end
      cda_pkg::ST_SQR: begin
        mant_d = m2[31] ? m2[31:1] : m2[30:0];
        frac_d = {frac_q[18:0], m2[31]};
        cnt_d  = cnt_q + 5'd1;
      end
      cda_pkg::ST_MUL: begin
        prod_d = lval * cda_pkg::LN2_Q32;
      end
      cda_pkg::ST_DLOAD: begin
        rem_d = '0;
        num_d = lnum[58:36];
        quo_d = '0;
        dsr_d = {16'b0, ent_q.weight};
        cnt_d = 5'd23;
      end
      cda_pkg::ST_DIV: begin
        rem_d = (trial >= {1'b0, dsr_q}) ? 33'(trial - {1'b0, dsr_q}) : trial[32:0];
        num_d = {num_q[21:0], 1'b0};
        quo_d = quo_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) term_d = quo_n;
      end
      cda_pkg::ST_ACC: begin
        if (go) begin
          if (term_w >= cda_pkg::SUM_MAX - sum_q) begin
            sum_d = cda_pkg::SUM_MAX;
            ovf_d = 1'b1;
          end else begin
            sum_d = sum_q + term_w;
          end
          if (ent_q.last) begin
            out_dist_d = sum_d;
            out_sat_d  = ovf_d;
            out_val_d  = 1'b1;
            sum_d      = '0;
            ovf_d      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cda_pkg::ST_IDLE;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
      out_val_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      ovf_q     <= ovf_d;
      out_val_q <= out_val_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d; norm_q <= norm_d; lz_q <= lz_d; mant_q <= mant_d; frac_q <= frac_d;
    prod_q <= prod_d; rem_q <= rem_d; dsr_q <= dsr_d; num_q <= num_d; quo_q <= quo_d;
    term_q <= term_d; out_dist_q <= out_dist_d; out_sat_q <= out_sat_d;
  end

  assign out_valid_o = out_val_q;
  assign distance_o  = out_dist_q;
  assign saturated_o = out_sat_q;

  `CDA_ASSERT_IMPL(a_mant_norm, state_q == cda_pkg::ST_SQR, mant_q[30], "mantissa not normalized")
  `CDA_ASSERT_IMPL(a_div_cnt, state_q == cda_pkg::ST_DIV, cnt_q != '0, "divider count ran out")
  `CDA_ASSERT_IMPL(a_ovf_sum, ovf_q, sum_q == cda_pkg::SUM_MAX, "overflow flag without full sum")

endmodule

// ===== rtl/core/coefficient_distance_accumulator_core.sv =====
`timescale 1ns / 1ps
// Coefficient distance accumulator. Each input beat carries one coefficient
// pair and its row; the per-pair term selected by metric_mode is added to an
// unsigned Q32.16 sum that saturates at its maximum, and the beat with tlast
// emits the sum and saturation flag and clears them. The front side registers
// config and classifies beats into a two-entry queue; the back side works one
// pair at a time, taking a queued pair whenever it is idle: count and
// unused modes go straight to accumulate, fraction runs a 17-step
// restoring divider (skipped when both values are zero), log modes run a
// 6-step normalize, 20 squaring steps on the 31x31 multiplier, one ln2
// multiply, a divider load and a 23-step divider. The result is valid the
// cycle after the last pair is summed; a result waiting on m_axis_tready
// holds the back side at the next last pair.
module coefficient_distance_accumulator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // coef_a[31:0], coef_b[63:32], row_index[71:64]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // distance[47:0]
  output logic        m_axis_tuser   // saturated
);

  cda_pkg::pair_t         push_pair, pop_pair;
  cda_pkg::queue_status_t qstat;
  logic                   pop;

  cda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .coef_a_i    (s_axis_tdata[31:0]),
    .coef_b_i    (s_axis_tdata[63:32]),
    .row_index_i (s_axis_tdata[71:64]),
    .last_pair_i (s_axis_tlast),
    .pair_o      (push_pair)
  );

  assign s_axis_tready = !qstat.full;

  cda_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (s_axis_tvalid),
    .wr_pair_i (push_pair),
    .pop_i     (pop),
    .rd_pair_o (pop_pair),
    .status_o  (qstat)
  );

  cda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pop_pair),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .distance_o  (m_axis_tdata),
    .saturated_o (m_axis_tuser)
  );

endmodule
